### design/fpx_pkg.sv
package fpx_pkg;

  // Queue geometry
  localparam int DEPTH         = 16;
  localparam int PAYLOAD_BITS  = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int IDX_W         = $clog2(DEPTH);
  localparam int CNT_W         = $clog2(DEPTH + 1);
  localparam int ENTRY_W       = PAYLOAD_BITS + PRIORITY_BITS;
  localparam int CMD_W         = 2;
  localparam int STATUS_W      = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PDEQ = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Control for the shared priority compare unit
  typedef struct packed {
    logic             en;     // a held entry is presented this cycle
    logic             first;  // it is the head entry, load unconditionally
    logic [CNT_W-1:0] off;    // its offset from the head
  } fpx_cmp_ctrl_t;

  // Physical slot of an entry at offset off from the head (wraps at DEPTH)
  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] head,
                                            input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - IDX_W){1'b0}}, head} + {1'b0, off};
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

### design/fpx_ram.sv
module fpx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/fpx_best.sv
module fpx_best (
  input  logic                                clk_i,
  input  fpx_pkg::fpx_cmp_ctrl_t              ctrl_i,
  input  logic [fpx_pkg::PRIORITY_BITS-1:0]   pri_i,
  input  logic [fpx_pkg::PAYLOAD_BITS-1:0]    pay_i,
  output logic [fpx_pkg::PRIORITY_BITS-1:0]   best_pri_o,
  output logic [fpx_pkg::PAYLOAD_BITS-1:0]    best_pay_o,
  output logic [fpx_pkg::CNT_W-1:0]           best_off_o
);

  logic [fpx_pkg::PRIORITY_BITS-1:0] best_pri_q;
  logic [fpx_pkg::PAYLOAD_BITS-1:0]  best_pay_q;
  logic [fpx_pkg::CNT_W-1:0]         best_off_q;
  logic                              take;

  // Strictly greater wins, so the earliest of equal maxima stays
  assign take = ctrl_i.en && (ctrl_i.first || (pri_i > best_pri_q));

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_pri_q <= pri_i;
      best_pay_q <= pay_i;
      best_off_q <= ctrl_i.off;
    end
  end

  assign best_pri_o = best_pri_q;
  assign best_pay_o = best_pay_q;
  assign best_off_o = best_off_q;

endmodule

### design/fifo_with_priority_extract.sv
// From input transaction to result valid: enqueue, errors and no-op pass the start and finish states;
// head dequeue adds a head read; priority dequeue adds a scan, a pick and a compaction.
// One command at a time: the next is accepted in the cycle after the result loads; a priority
// dequeue takes longest, its length set by the RAM ports (scan, then compaction).
// rst_ni is asynchronous, active low: queue empties, head returns to slot 0.
// Entry storage is not cleared; only held entries are ever read.
module fifo_with_priority_extract (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [fpx_pkg::CMD_W-1:0]           command_i,
  input  logic [fpx_pkg::PAYLOAD_BITS-1:0]    payload_i,
  input  logic [fpx_pkg::PRIORITY_BITS-1:0]   priority_req_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [fpx_pkg::STATUS_W-1:0]        status_o,
  output logic [fpx_pkg::PAYLOAD_BITS-1:0]    out_payload_o,
  output logic [fpx_pkg::PRIORITY_BITS-1:0]   out_priority_o,
  output logic [fpx_pkg::CNT_W-1:0]           occupancy_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_HEAD  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_PICK  = 3'd4;
  localparam logic [2:0] S_MOVE  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state_q, state_d;

  logic [fpx_pkg::CMD_W-1:0]         cmd_q, cmd_d;
  logic [fpx_pkg::PAYLOAD_BITS-1:0]  pay_q, pay_d;
  logic [fpx_pkg::PRIORITY_BITS-1:0] pri_q, pri_d;

  logic [fpx_pkg::IDX_W-1:0] head_q, head_d;
  logic [fpx_pkg::CNT_W-1:0] count_q, count_d;
  logic [fpx_pkg::CNT_W-1:0] off_q, off_d;
  logic                      pend_q, pend_d;

  logic [fpx_pkg::STATUS_W-1:0]      res_status_q, res_status_d;
  logic [fpx_pkg::PAYLOAD_BITS-1:0]  res_pay_q, res_pay_d;
  logic [fpx_pkg::PRIORITY_BITS-1:0] res_pri_q, res_pri_d;

  logic                              out_valid_q, out_valid_d;
  logic                              out_load;
  logic [fpx_pkg::STATUS_W-1:0]      out_status_q;
  logic [fpx_pkg::PAYLOAD_BITS-1:0]  out_pay_q;
  logic [fpx_pkg::PRIORITY_BITS-1:0] out_pri_q;
  logic [fpx_pkg::CNT_W-1:0]         out_occ_q;

  // Entry RAM ports
  logic                         ram_we, ram_re;
  logic [fpx_pkg::IDX_W-1:0]    ram_waddr, ram_raddr;
  logic [fpx_pkg::ENTRY_W-1:0]  ram_wdata, ram_rdata;
  logic [fpx_pkg::PAYLOAD_BITS-1:0]  rd_pay;
  logic [fpx_pkg::PRIORITY_BITS-1:0] rd_pri;

  // Compare unit
  fpx_pkg::fpx_cmp_ctrl_t            cmp_ctrl;
  logic [fpx_pkg::PRIORITY_BITS-1:0] best_pri;
  logic [fpx_pkg::PAYLOAD_BITS-1:0]  best_pay;
  logic [fpx_pkg::CNT_W-1:0]         best_off;

  assign rd_pri = ram_rdata[fpx_pkg::PRIORITY_BITS-1:0];
  assign rd_pay = ram_rdata[fpx_pkg::ENTRY_W-1:fpx_pkg::PRIORITY_BITS];

  fpx_ram #(
    .WIDTH (fpx_pkg::ENTRY_W),
    .DEPTH (fpx_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  fpx_best u_best (
    .clk_i      (clk_i),
    .ctrl_i     (cmp_ctrl),
    .pri_i      (rd_pri),
    .pay_i      (rd_pay),
    .best_pri_o (best_pri),
    .best_pay_o (best_pay),
    .best_off_o (best_off)
  );

  // Sequencer
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    pay_d        = pay_q;
    pri_d        = pri_q;
    head_d       = head_q;
    count_d      = count_q;
    off_d        = off_q;
    pend_d       = pend_q;
    res_status_d = res_status_q;
    res_pay_d    = res_pay_q;
    res_pri_d    = res_pri_q;
    in_ready_o   = 1'b0;
    out_load     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = {pay_q, pri_q};
    ram_re       = 1'b0;
    ram_raddr    = '0;
    cmp_ctrl     = '0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d   = command_i;
          pay_d   = payload_i;
          pri_d   = priority_req_i;
          state_d = S_START;
        end
      end

      S_START: begin
        res_status_d = fpx_pkg::ST_OK;
        res_pay_d    = '0;
        res_pri_d    = '0;
        off_d        = '0;
        state_d      = S_FIN;
        case (cmd_q)
          fpx_pkg::CMD_ENQ: begin
            if (count_q >= fpx_pkg::CNT_W'(fpx_pkg::DEPTH)) begin
              res_status_d = fpx_pkg::ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = fpx_pkg::slot(head_q, count_q);
              count_d   = count_q + 1'b1;
            end
          end
          fpx_pkg::CMD_DEQ, fpx_pkg::CMD_PDEQ: begin
            if (count_q == '0) begin
              res_status_d = fpx_pkg::ST_EMPTY;
            end else if (cmd_q == fpx_pkg::CMD_DEQ) begin
              ram_re    = 1'b1;
              ram_raddr = head_q;
              state_d   = S_HEAD;
            end else begin
              state_d = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end

      S_HEAD: begin
        res_pay_d = rd_pay;
        res_pri_d = rd_pri;
        head_d    = fpx_pkg::slot(head_q, fpx_pkg::CNT_W'(1));
        count_d   = count_q - 1'b1;
        state_d   = S_FIN;
      end

      // Stream held entries through the compare unit, one per cycle
      S_SCAN: begin
        if (off_q < count_q) begin
          ram_re    = 1'b1;
          ram_raddr = fpx_pkg::slot(head_q, off_q);
          off_d     = off_q + 1'b1;
        end
        cmp_ctrl.en    = (off_q != '0);
        cmp_ctrl.first = (off_q == fpx_pkg::CNT_W'(1));
        cmp_ctrl.off   = off_q - 1'b1;
        if (off_q != '0 && off_q == count_q) begin
          state_d = S_PICK;
        end
      end

      S_PICK: begin
        res_pay_d = best_pay;
        res_pri_d = best_pri;
        count_d   = count_q - 1'b1;
        off_d     = best_off + 1'b1;
        pend_d    = 1'b0;
        state_d   = S_MOVE;
      end

      // Close the gap: read offset k+1, write it to offset k next cycle
      S_MOVE: begin
        if (off_q <= count_q) begin
          ram_re    = 1'b1;
          ram_raddr = fpx_pkg::slot(head_q, off_q);
          off_d     = off_q + 1'b1;
          pend_d    = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = fpx_pkg::slot(head_q, off_q - fpx_pkg::CNT_W'(2));
          ram_wdata = ram_rdata;
        end
        if (!pend_q && off_q > count_q) begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & ~out_ready_i);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      off_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      off_q       <= off_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Command and result payload registers
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    pay_q        <= pay_d;
    pri_q        <= pri_d;
    res_status_q <= res_status_d;
    res_pay_q    <= res_pay_d;
    res_pri_q    <= res_pri_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_pay_q    <= res_pay_q;
      out_pri_q    <= res_pri_q;
      out_occ_q    <= count_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign out_payload_o  = out_pay_q;
  assign out_priority_o = out_pri_q;
  assign occupancy_o    = out_occ_q;

  // Occupancy never exceeds the queue depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= fpx_pkg::CNT_W'(fpx_pkg::DEPTH))
    else $error("occupancy above depth");

  // A scan only runs over a non-empty queue
  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (count_q != '0))
    else $error("priority scan on empty queue");

  // The winner found by the scan is a held entry
  a_best_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PICK) |-> (best_off < count_q))
    else $error("selected entry outside queue");

  // Compaction never reads and writes the same slot in one cycle
  a_move_no_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("RAM read and write collide");

  // A result is loaded only when the output register is free
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten");

endmodule

### sim/tb.sv
module tb;
  import fpx_pkg::*;

  // Command three does nothing but report the occupancy
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  // Cycles without any transaction before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  // Settling time after the last result, covers a full priority dequeue
  localparam int TAIL_CYCLES = 2 * DEPTH + 10;

  typedef struct packed {
    logic [PAYLOAD_BITS-1:0]  handle;
    logic [PRIORITY_BITS-1:0] prio;
  } held_entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [PAYLOAD_BITS-1:0]  handle;
    logic [PRIORITY_BITS-1:0] prio;
    logic [CNT_W-1:0]         occ;
  } queue_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [CMD_W-1:0]         command;
  logic [PAYLOAD_BITS-1:0]  payload;
  logic [PRIORITY_BITS-1:0] priority_req;
  logic                     out_valid;
  logic                     out_ready;
  logic [STATUS_W-1:0]      status;
  logic [PAYLOAD_BITS-1:0]  out_payload;
  logic [PRIORITY_BITS-1:0] out_priority;
  logic [CNT_W-1:0]         occupancy;

  // Shadow copy of the queue contents, oldest first
  held_entry_t   held_entries[$];
  // Results still owed by the block, oldest first
  queue_result_t pending_results[$];

  int  error_count;
  int  quiet_cycles;
  bit  in_idle_on;
  bit  out_idle_on;

  fifo_with_priority_extract dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .payload_i      (payload),
    .priority_req_i (priority_req),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .out_payload_o  (out_payload),
    .out_priority_o (out_priority),
    .occupancy_o    (occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Apply one command to the shadow queue and return what the block should report
  function automatic queue_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                  input logic [PAYLOAD_BITS-1:0] handle,
                                                  input logic [PRIORITY_BITS-1:0] prio);
    queue_result_t res;
    held_entry_t   taken;
    int            best;
    res = '0;
    res.status = ST_OK;
    case (cmd)
      CMD_ENQ: begin
        if (held_entries.size() >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          held_entries.push_back('{handle: handle, prio: prio});
        end
      end
      CMD_DEQ, CMD_PDEQ: begin
        if (held_entries.size() == 0) begin
          res.status = ST_EMPTY;
        end else if (cmd == CMD_DEQ) begin
          taken = held_entries.pop_front();
          res.handle = taken.handle;
          res.prio   = taken.prio;
        end else begin
          // earliest entry wins a tie: only a strictly greater priority moves it
          best = 0;
          for (int k = 1; k < held_entries.size(); k++) begin
            if (held_entries[k].prio > held_entries[best].prio) begin
              best = k;
            end
          end
          taken = held_entries[best];
          held_entries.delete(best);
          res.handle = taken.handle;
          res.prio   = taken.prio;
        end
      end
      default: ;
    endcase
    res.occ = CNT_W'(held_entries.size());
    return res;
  endfunction

  // Drive one command; returns at the falling edge after it is accepted
  task automatic send_cmd(input logic [CMD_W-1:0] cmd,
                          input logic [PAYLOAD_BITS-1:0] handle,
                          input logic [PRIORITY_BITS-1:0] prio);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    command      = cmd;
    payload      = handle;
    priority_req = prio;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_command(cmd, handle, prio));
    @(negedge clk);
  endtask

  // Result sink: random back-pressure, compare against the oldest expectation
  initial begin
    queue_result_t want;
    int            gap;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      gap = out_idle_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected: status %0d payload %0h",
               status, out_payload);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          error_count++;
        end
        if (out_payload !== want.handle) begin
          $error("out_payload: expected %0h, got %0h", want.handle, out_payload);
          error_count++;
        end
        if (out_priority !== want.prio) begin
          $error("out_priority: expected %0d, got %0d", want.prio, out_priority);
          error_count++;
        end
        if (occupancy !== want.occ) begin
          $error("occupancy: expected %0d, got %0d", want.occ, occupancy);
          error_count++;
        end
      end
    end
  end

  // Hang detection: any transaction on either side restarts the count
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Dequeues and no-ops on an empty queue
  task automatic test_empty_queue();
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    send_cmd(CMD_DEQ, 16'hFFFF, 8'hFF);
    send_cmd(CMD_PDEQ, 16'hFFFF, 8'hFF);
    send_cmd(CMD_NOP, 16'h0000, 8'h00);
  endtask

  // Fill to the top, then push once more and send a no-op while full
  task automatic test_fill_to_full();
    logic [PRIORITY_BITS-1:0] prio;
    logic [PAYLOAD_BITS-1:0]  handle;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    for (int i = 0; i < DEPTH; i++) begin
      handle = PAYLOAD_BITS'($urandom_range(1, 16'hFFFE));
      prio   = PRIORITY_BITS'($urandom_range(1, 8'hFE));
      if (i == 0) begin
        handle = '0;
        prio   = '0;
      end else if (i == DEPTH - 1) begin
        handle = '1;
        prio   = '1;
      end else if (i == 5) begin
        // an earlier copy of the top priority, so ties get exercised
        prio = '1;
      end
      send_cmd(CMD_ENQ, handle, prio);
    end
    send_cmd(CMD_ENQ, 16'h5A5A, 8'h80);
    send_cmd(CMD_NOP, 16'hFFFF, 8'hFF);
  endtask

  // Tied maxima come out earliest first, then plain head removal and one more priority dequeue
  task automatic test_priority_extract();
    send_cmd(CMD_PDEQ, 16'h0000, 8'h00);
    send_cmd(CMD_PDEQ, 16'h0000, 8'h00);
    send_cmd(CMD_DEQ, 16'h0000, 8'h00);
    send_cmd(CMD_PDEQ, 16'h0000, 8'h00);
  endtask

  // Random command mix in bursts that push the queue up, drain it or keep it balanced
  task automatic test_random_traffic(input int n_cmds, input bit in_idle, input bit out_idle);
    int                       trend;
    int                       enq_pct;
    int                       roll;
    logic [CMD_W-1:0]         cmd;
    logic [PRIORITY_BITS-1:0] prio;
    in_idle_on  = in_idle;
    out_idle_on = out_idle;
    trend = 2;
    for (int i = 0; i < n_cmds; i++) begin
      if (i % 40 == 0) begin
        trend = $urandom_range(0, 2);
      end
      enq_pct = (trend == 0) ? 75 : (trend == 1) ? 25 : 50;
      roll = $urandom_range(0, 99);
      if (roll < enq_pct) begin
        cmd = CMD_ENQ;
      end else if (roll < 97) begin
        cmd = $urandom_range(0, 1) ? CMD_DEQ : CMD_PDEQ;
      end else begin
        cmd = CMD_NOP;
      end
      // narrow priorities now and then so ties are common
      if ($urandom_range(0, 3) == 0) begin
        prio = PRIORITY_BITS'($urandom_range(0, 3));
      end else begin
        prio = PRIORITY_BITS'($urandom_range(0, 255));
      end
      send_cmd(cmd, PAYLOAD_BITS'($urandom_range(0, 65535)), prio);
    end
  endtask

  initial begin
    error_count  = 0;
    quiet_cycles = 0;
    in_idle_on   = 1'b0;
    out_idle_on  = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    command      = CMD_NOP;
    payload      = '0;
    priority_req = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_queue();
    test_fill_to_full();
    test_priority_extract();
    test_random_traffic(440, 1'b0, 1'b0);
    test_random_traffic(440, 1'b1, 1'b1);
    test_random_traffic(440, 1'b1, 1'b0);
    test_random_traffic(440, 1'b0, 1'b1);
    in_valid = 1'b0;

    // drain, then give a stray result time to show up
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
